[design/prqs_pkg.sv]
// Shared types and codes for the priority ready queue scheduler.
// Holds the request and response word layouts, operation and status codes,
// and the sequencer state type. No dependencies.
package prqs_pkg;

   // Operation codes carried in the request word.
   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;
   localparam logic [1:0] OP_REMOVE  = 2'd2;
   localparam logic [1:0] OP_CHANGE  = 2'd3;

   // Status codes returned in the response word.
   localparam logic [1:0] STATUS_DONE   = 2'd0;
   localparam logic [1:0] STATUS_EMPTY  = 2'd1;
   localparam logic [1:0] STATUS_QUEUE  = 2'd2;
   localparam logic [1:0] STATUS_REJECT = 2'd3;

   // One request word.
   typedef struct packed {
      logic [1:0] operation;
      logic [3:0] pid;
      logic [1:0] priority_req;
   } req_word_type;

   // One response word.
   typedef struct packed {
      logic [3:0] pid_out;
      logic [1:0] status;
   } rsp_word_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_UNLINK,
      ST_APPEND,
      ST_SEAL,
      ST_FINISH
   } fsm_state_type;

endpackage

[design/priority_ready_queue_scheduler.sv]
// Multilevel priority ready queue: one FIFO of process ids per level,
// held as doubly linked lists in link memories, under a small sequencer.
// Depends on prqs_pkg.
//
// A request that touches no list (rejected, failed, or a level change of an
// idle process) goes from decode to finish; dequeue and remove unlink,
// enqueue appends and seals, a priority change of a queued process does all
// three. One request is in work at a time: none is taken until the last
// response is loaded. The sequencer makes at most one write per link memory
// each step, and a stalled response holds it. Synchronous active-high reset
// empties all queues and clears locked_ff.
module priority_ready_queue_scheduler
   import prqs_pkg::*;
#(
   parameter int NUM_PROCS  = 16,
   parameter int NUM_LEVELS = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [3:0]   csr_wdata
);

   localparam int LINK_W = $clog2(NUM_PROCS + 1);
   localparam int PID_W  = $clog2(NUM_PROCS);
   localparam int LVL_W  = $clog2(NUM_LEVELS);
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_PROCS);

   // Control and configuration registers.
   fsm_state_type     state_ff, state_in;
   logic [3:0]        locked_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;
   logic [LINK_W-1:0] head_ff [NUM_LEVELS];
   logic [LINK_W-1:0] head_in [NUM_LEVELS];
   logic [LINK_W-1:0] tail_ff [NUM_LEVELS];
   logic [LINK_W-1:0] tail_in [NUM_LEVELS];
   logic              queued_ff [NUM_PROCS];
   logic              queued_in [NUM_PROCS];

   // Working registers for the word in flight.
   req_word_type      req_ff;
   logic [PID_W-1:0]  tgt_ff, tgt_in;
   logic [3:0]        res_pid_ff, res_pid_in;
   logic [1:0]        res_status_ff, res_status_in;

   // Link and level memories with registered read data.
   logic [LINK_W-1:0] next_mem [NUM_PROCS];
   logic [LINK_W-1:0] prev_mem [NUM_PROCS];
   logic [LVL_W-1:0]  lvl_mem [NUM_PROCS];
   logic [LINK_W-1:0] next_rd_ff;
   logic [LINK_W-1:0] prev_rd_ff;
   logic [LVL_W-1:0]  lvl_rd_ff;

   // Memory port controls.
   logic              next_we, prev_we, lvl_we, mem_re;
   logic [PID_W-1:0]  next_waddr, prev_waddr, lvl_waddr;
   logic [LINK_W-1:0] next_wdata, prev_wdata;
   logic [LVL_W-1:0]  lvl_wdata;

   // Decode results.
   logic              any_head;
   logic [LVL_W-1:0]  enc_lvl;
   logic              pid_ok, lvl_ok;
   logic [PID_W-1:0]  pid_idx;
   logic [LVL_W-1:0]  lvl_idx;
   fsm_state_type     dec_state;
   logic [1:0]        dec_status;
   logic [PID_W-1:0]  dec_tgt;
   logic              dec_set_level;

   // Unlink and append helpers.
   logic              pr_ok, nx_ok, t_ok;
   logic [LINK_W-1:0] app_tail;
   logic              rsp_load;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Priority encoder over the level heads: lowest non-empty level wins.
   always_comb begin
      any_head = 1'b0;
      enc_lvl  = '0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (head_ff[i] < NULL_LINK) begin
            any_head = 1'b1;
            enc_lvl  = LVL_W'(i);
         end
      end
   end

   // Classify the latched word and pick the process it works on.
   always_comb begin
      pid_ok        = 32'(req_ff.pid) < NUM_PROCS;
      lvl_ok        = 32'(req_ff.priority_req) < NUM_LEVELS;
      pid_idx       = PID_W'(req_ff.pid);
      lvl_idx       = LVL_W'(req_ff.priority_req);
      dec_state     = ST_FINISH;
      dec_status    = STATUS_DONE;
      dec_tgt       = pid_idx;
      dec_set_level = 1'b0;
      if (req_ff.operation == OP_DEQUEUE) begin
         dec_tgt = PID_W'(head_ff[enc_lvl]);
         if (any_head) begin
            dec_state = ST_UNLINK;
         end else begin
            dec_status = STATUS_EMPTY;
         end
      end else if (!pid_ok) begin
         dec_status = STATUS_REJECT;
      end else begin
         unique case (req_ff.operation)
            OP_ENQUEUE: begin
               if (!lvl_ok) begin
                  dec_status = STATUS_REJECT;
               end else if (queued_ff[pid_idx]) begin
                  dec_status = STATUS_QUEUE;
               end else begin
                  dec_state = ST_APPEND;
               end
            end
            OP_REMOVE: begin
               if (!queued_ff[pid_idx]) begin
                  dec_status = STATUS_QUEUE;
               end else begin
                  dec_state = ST_UNLINK;
               end
            end
            OP_CHANGE: begin
               if (req_ff.pid == locked_ff || !lvl_ok) begin
                  dec_status = STATUS_REJECT;
               end else if (queued_ff[pid_idx]) begin
                  dec_state = ST_UNLINK;
               end else begin
                  dec_set_level = 1'b1;
               end
            end
            default: begin
               dec_status = STATUS_REJECT;
            end
         endcase
      end
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = dec_state;
         end
         ST_UNLINK: begin
            state_in = (req_ff.operation == OP_CHANGE) ? ST_APPEND : ST_FINISH;
         end
         ST_APPEND: begin
            state_in = ST_SEAL;
         end
         ST_SEAL: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Link fix-up helpers for the unlink and append steps.
   assign pr_ok    = prev_rd_ff < NULL_LINK;
   assign nx_ok    = next_rd_ff < NULL_LINK;
   assign app_tail = tail_ff[lvl_idx];
   assign t_ok     = app_tail < NULL_LINK;
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // Datapath controls for each sequencer step.
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      queued_in     = queued_ff;
      tgt_in        = tgt_ff;
      res_pid_in    = res_pid_ff;
      res_status_in = res_status_ff;
      mem_re        = 1'b0;
      next_we       = 1'b0;
      next_waddr    = tgt_ff;
      next_wdata    = NULL_LINK;
      prev_we       = 1'b0;
      prev_waddr    = tgt_ff;
      prev_wdata    = NULL_LINK;
      lvl_we        = 1'b0;
      lvl_waddr     = tgt_ff;
      lvl_wdata     = lvl_idx;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_DECODE: begin
            // Read the links and level of the target for a possible unlink.
            mem_re        = 1'b1;
            tgt_in        = dec_tgt;
            res_pid_in    = '0;
            res_status_in = dec_status;
            lvl_we        = dec_set_level;
            lvl_waddr     = pid_idx;
         end
         ST_UNLINK: begin
            // Bridge the neighbors, or move the head or tail past the target.
            if (pr_ok) begin
               next_we    = 1'b1;
               next_waddr = PID_W'(prev_rd_ff);
               next_wdata = next_rd_ff;
            end else begin
               head_in[lvl_rd_ff] = nx_ok ? next_rd_ff : NULL_LINK;
            end
            if (nx_ok) begin
               prev_we    = 1'b1;
               prev_waddr = PID_W'(next_rd_ff);
               prev_wdata = prev_rd_ff;
            end else begin
               tail_in[lvl_rd_ff] = pr_ok ? prev_rd_ff : NULL_LINK;
            end
            queued_in[tgt_ff] = 1'b0;
            if (req_ff.operation != OP_CHANGE) begin
               res_pid_in = 4'(tgt_ff);
            end
         end
         ST_APPEND: begin
            // Hook the target behind the current tail of its new level.
            prev_we    = 1'b1;
            prev_wdata = t_ok ? app_tail : NULL_LINK;
            if (t_ok) begin
               next_we    = 1'b1;
               next_waddr = PID_W'(app_tail);
               next_wdata = LINK_W'(tgt_ff);
            end else begin
               head_in[lvl_idx] = LINK_W'(tgt_ff);
            end
            tail_in[lvl_idx]  = LINK_W'(tgt_ff);
            queued_in[tgt_ff] = 1'b1;
            lvl_we            = 1'b1;
         end
         ST_SEAL: begin
            // The new tail has no successor.
            next_we = 1'b1;
         end
         ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   // Response register: loaded from the finish step, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (rsp_load) begin
         rsp_valid_in        = 1'b1;
         rsp_word_in.pid_out = res_pid_ff;
         rsp_word_in.status  = res_status_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         locked_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= NULL_LINK;
            tail_ff[i] <= NULL_LINK;
         end
         for (int i = 0; i < NUM_PROCS; i++) begin
            queued_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         queued_ff    <= queued_in;
         if (csr_valid && csr_ready) begin
            locked_ff <= csr_wdata;
         end
      end
   end

   // Payload registers without reset.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_word;
      end
      tgt_ff        <= tgt_in;
      res_pid_ff    <= res_pid_in;
      res_status_ff <= res_status_in;
      rsp_word_ff   <= rsp_word_in;
   end

   // Link and level memories.
   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      if (lvl_we) begin
         lvl_mem[lvl_waddr] <= lvl_wdata;
      end
      if (mem_re) begin
         next_rd_ff <= next_mem[dec_tgt];
         prev_rd_ff <= prev_mem[dec_tgt];
         lvl_rd_ff  <= lvl_mem[dec_tgt];
      end
   end

   // An accepted word always starts with the decode step.
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_DECODE)
      else $error("accepted word did not enter decode");

   // Only queued processes are ever unlinked.
   a_unlink_queued: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UNLINK |-> queued_ff[tgt_ff])
      else $error("unlink of a process that is not queued");

   // After the append step the target is marked queued.
   a_seal_queued: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEAL |-> queued_ff[tgt_ff])
      else $error("appended process not marked queued");

   // A failed request never reports a process id.
   a_fail_no_pid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.status != STATUS_DONE |-> rsp_word_ff.pid_out == '0)
      else $error("failed request carries a process id");

   // Each level's head and tail are empty together.
   for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_level_chk
      a_head_tail: assert property (@(posedge clock) disable iff (reset)
         (head_ff[g] == NULL_LINK) == (tail_ff[g] == NULL_LINK))
         else $error("level head and tail disagree on empty");
   end

endmodule
